// ----- design/svpwm_pkg.sv -----
`timescale 1ns / 1ps
package svpwm_pkg;

  localparam int DIV_STEPS = 16;
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;

  localparam logic [15:0] PERIOD_RESET = 16'd4200;
  localparam logic [14:0] DC_BUS_RESET = 15'd24000;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_DC_BUS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
  } in_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] time_phase_u;
    logic [15:0] time_phase_v;
    logic [15:0] time_phase_w;
  } out_t;

  // sideband that travels with each word through the pipeline
  typedef struct packed {
    logic        valid;
    logic [2:0]  sector;
    logic [15:0] ts;
  } ctrl_t;

endpackage

// ----- design/svpwm_div.sv -----
`timescale 1ns / 1ps
module svpwm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  svpwm_pkg::ctrl_t        in_ctrl,
  input  logic [49:0]             num_a,
  input  logic [49:0]             num_b,
  input  logic [34:0]             den,
  output svpwm_pkg::ctrl_t        out_ctrl,
  output logic [15:0]             quo_a,
  output logic [15:0]             quo_b
);
  import svpwm_pkg::*;

  // restoring divider, one quotient bit per stage; quotient known to fit 16 bits
  // s_* feed stage k, r_* hold what stage k hands on
  ctrl_t       s_ctrl  [DIV_STEPS];
  logic [34:0] s_rem_a [DIV_STEPS];
  logic [34:0] s_rem_b [DIV_STEPS];
  logic [15:0] s_lo_a  [DIV_STEPS];
  logic [15:0] s_lo_b  [DIV_STEPS];
  logic [15:0] s_q_a   [DIV_STEPS];
  logic [15:0] s_q_b   [DIV_STEPS];
  logic [34:0] s_dv    [DIV_STEPS];

  ctrl_t       r_ctrl  [DIV_STEPS];
  logic [15:0] r_q_a   [DIV_STEPS];
  logic [15:0] r_q_b   [DIV_STEPS];
  logic [34:0] r_rem_a [DIV_STEPS-1];
  logic [34:0] r_rem_b [DIV_STEPS-1];
  logic [15:0] r_lo_a  [DIV_STEPS-1];
  logic [15:0] r_lo_b  [DIV_STEPS-1];
  logic [34:0] r_dv    [DIV_STEPS-1];

  logic [35:0] try_a [DIV_STEPS];
  logic [35:0] try_b [DIV_STEPS];
  logic        ge_a  [DIV_STEPS];
  logic        ge_b  [DIV_STEPS];

  always_comb begin
    s_ctrl[0]  = in_ctrl;
    s_rem_a[0] = {1'b0, num_a[49:16]};
    s_rem_b[0] = {1'b0, num_b[49:16]};
    s_lo_a[0]  = num_a[15:0];
    s_lo_b[0]  = num_b[15:0];
    s_q_a[0]   = '0;
    s_q_b[0]   = '0;
    s_dv[0]    = den;
    for (int k = 1; k < DIV_STEPS; k++) begin
      s_ctrl[k]  = r_ctrl[k-1];
      s_rem_a[k] = r_rem_a[k-1];
      s_rem_b[k] = r_rem_b[k-1];
      s_lo_a[k]  = r_lo_a[k-1];
      s_lo_b[k]  = r_lo_b[k-1];
      s_q_a[k]   = r_q_a[k-1];
      s_q_b[k]   = r_q_b[k-1];
      s_dv[k]    = r_dv[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      try_a[k] = {s_rem_a[k], s_lo_a[k][15]};
      try_b[k] = {s_rem_b[k], s_lo_b[k][15]};
      ge_a[k]  = try_a[k] >= {1'b0, s_dv[k]};
      ge_b[k]  = try_b[k] >= {1'b0, s_dv[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (rst) r_ctrl[k] <= '0;
      else r_ctrl[k] <= s_ctrl[k];
      r_q_a[k] <= {s_q_a[k][14:0], ge_a[k]};
      r_q_b[k] <= {s_q_b[k][14:0], ge_b[k]};
    end
    for (int k = 0; k < DIV_STEPS - 1; k++) begin
      r_rem_a[k] <= ge_a[k] ? 35'(try_a[k] - {1'b0, s_dv[k]}) : try_a[k][34:0];
      r_rem_b[k] <= ge_b[k] ? 35'(try_b[k] - {1'b0, s_dv[k]}) : try_b[k][34:0];
      r_lo_a[k]  <= {s_lo_a[k][14:0], 1'b0};
      r_lo_b[k]  <= {s_lo_b[k][14:0], 1'b0};
      r_dv[k]    <= s_dv[k];
    end
  end

  assign out_ctrl = r_ctrl[DIV_STEPS-1];
  assign quo_a    = r_q_a[DIV_STEPS-1];
  assign quo_b    = r_q_b[DIV_STEPS-1];

endmodule

// ----- design/svpwm_sector_and_dwell_times.sv -----
`timescale 1ns / 1ps
// Seven-segment space-vector PWM: sector and phase compare times from one
// (alpha, beta) vector. A word is taken whenever start is high; busy is always
// low, so one word per clock is sustained. Each result appears with done once
// it has passed four front stages (sector, operand select, sqrt3 multiply,
// period multiply), a 16-stage one-bit-per-stage divider and the output
// register. The receiver cannot stall; results must be captured in the cycle
// done is high. Configuration takes effect on words started after the write.
module svpwm_sector_and_dwell_times (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  svpwm_pkg::in_t    volt_in,
  output logic              done,
  output svpwm_pkg::out_t   result,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_data
);
  import svpwm_pkg::*;

  logic [15:0] period_ticks;
  logic [14:0] dc_bus_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_RESET;
      dc_bus_level <= DC_BUS_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_PERIOD: period_ticks <= cfg_data;
        REG_DC_BUS: dc_bus_level <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // stage 1: projections and sector
  logic signed [33:0] prod_a, bq, x0, x1, x2;
  logic [2:0] code, sec1;
  always_comb begin
    prod_a = 34'($signed({1'b0, SQRT3_Q16}) * volt_in.volt_alpha);
    bq     = {{2{volt_in.volt_beta[15]}}, volt_in.volt_beta, 16'h0};
    x0     = {volt_in.volt_beta[15], volt_in.volt_beta, 17'h0};
    x1     = prod_a - bq;
    x2     = -prod_a - bq;
    code   = {!x2[33] && x2 != 0, !x1[33] && x1 != 0, !x0[33] && x0 != 0};
    case (code)
      3'd1: sec1 = 3'd2;
      3'd2: sec1 = 3'd6;
      3'd3: sec1 = 3'd1;
      3'd4: sec1 = 3'd4;
      3'd5: sec1 = 3'd3;
      3'd6: sec1 = 3'd5;
      default: sec1 = 3'd0;
    endcase
  end

  ctrl_t c1, c2, c3, c4;
  logic signed [33:0] r1_x0, r1_x1, r1_x2;
  logic [14:0] udc1, udc2, udc3;

  always_ff @(posedge clk) begin
    if (rst) c1 <= '0;
    else c1 <= '{valid: accept, sector: sec1, ts: period_ticks};
    udc1   <= (dc_bus_level == '0) ? 15'd1 : dc_bus_level;
    r1_x0  <= x0;
    r1_x1  <= x1;
    r1_x2  <= x2;
  end

  // stage 2: pick the two projections that set the dwells
  logic signed [33:0] sel_a, sel_b;
  always_comb begin
    case (c1.sector)
      3'd1: begin sel_a = r1_x1; sel_b = r1_x0; end
      3'd2: begin sel_a = r1_x1; sel_b = r1_x2; end
      3'd3: begin sel_a = r1_x0; sel_b = r1_x2; end
      3'd4: begin sel_a = r1_x0; sel_b = r1_x1; end
      3'd5: begin sel_a = r1_x2; sel_b = r1_x1; end
      3'd6: begin sel_a = r1_x2; sel_b = r1_x0; end
      default: begin sel_a = '0; sel_b = '0; end
    endcase
  end

  logic [32:0] mag_a, mag_b;
  always_ff @(posedge clk) begin
    if (rst) c2 <= '0;
    else c2 <= c1;
    udc2  <= udc1;
    mag_a <= sel_a[33] ? 33'(-sel_a) : sel_a[32:0];
    mag_b <= sel_b[33] ? 33'(-sel_b) : sel_b[32:0];
  end

  // stage 3: scale by sqrt3
  logic [49:0] pa, pb;
  assign pa = SQRT3_Q16 * mag_a;
  assign pb = SQRT3_Q16 * mag_b;

  logic [33:0] da, db;
  always_ff @(posedge clk) begin
    if (rst) c3 <= '0;
    else c3 <= c2;
    udc3 <= udc2;
    da   <= pa[49:16];
    db   <= pb[49:16];
  end

  // stage 4: numerators and divisor; overmodulation divides by the dwell sum
  logic [34:0] dsum, qlim;
  assign dsum = {1'b0, da} + {1'b0, db};
  assign qlim = {2'b0, udc3, 18'h0};

  logic [49:0] num_a, num_b;
  logic [34:0] den;
  always_ff @(posedge clk) begin
    if (rst) c4 <= '0;
    else c4 <= c3;
    num_a <= c3.ts * da;
    num_b <= c3.ts * db;
    den   <= (dsum > qlim) ? dsum : qlim;
  end

  ctrl_t       cd;
  logic [15:0] ta, tb;

  svpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_ctrl  (c4),
    .num_a    (num_a),
    .num_b    (num_b),
    .den      (den),
    .out_ctrl (cd),
    .quo_a    (ta),
    .quo_b    (tb)
  );

  // final stage: zero time, phase routing, clamp
  logic [16:0] tab, rest;
  logic [15:0] t0;
  logic [17:0] t_lead, t_mid, t_last;
  logic [15:0] c_lead, c_mid, c_last;
  out_t        res_next;

  always_comb begin
    tab    = {1'b0, ta} + {1'b0, tb};
    rest   = {1'b0, cd.ts} - tab;
    t0     = (tab > {1'b0, cd.ts}) ? 16'd0 : {2'b0, rest[15:2]};
    t_lead = {1'b0, tab} + {2'b0, t0};
    t_mid  = {2'b0, tb} + {2'b0, t0};
    t_last = {2'b0, t0};
    c_lead = (t_lead > {2'b0, cd.ts}) ? cd.ts : t_lead[15:0];
    c_mid  = (t_mid  > {2'b0, cd.ts}) ? cd.ts : t_mid[15:0];
    c_last = (t_last > {2'b0, cd.ts}) ? cd.ts : t_last[15:0];
    res_next.sector = cd.sector;
    case (cd.sector)
      3'd1: begin
        res_next.time_phase_u = c_lead; res_next.time_phase_v = c_mid;
        res_next.time_phase_w = c_last;
      end
      3'd2: begin
        res_next.time_phase_v = c_lead; res_next.time_phase_u = c_mid;
        res_next.time_phase_w = c_last;
      end
      3'd3: begin
        res_next.time_phase_v = c_lead; res_next.time_phase_w = c_mid;
        res_next.time_phase_u = c_last;
      end
      3'd4: begin
        res_next.time_phase_w = c_lead; res_next.time_phase_v = c_mid;
        res_next.time_phase_u = c_last;
      end
      3'd5: begin
        res_next.time_phase_w = c_lead; res_next.time_phase_u = c_mid;
        res_next.time_phase_v = c_last;
      end
      3'd6: begin
        res_next.time_phase_u = c_lead; res_next.time_phase_w = c_mid;
        res_next.time_phase_v = c_last;
      end
      default: begin
        res_next.time_phase_u = '0; res_next.time_phase_v = '0;
        res_next.time_phase_w = '0;
      end
    endcase
  end

  logic [15:0] ts_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cd.valid;
    end
    result <= res_next;
    ts_out <= cd.ts;
  end

  // zero vector gives all-zero times
  a_zero_sector: assert property (@(posedge clk) disable iff (rst)
    done && result.sector == 3'd0 |->
      result.time_phase_u == '0 && result.time_phase_v == '0 &&
      result.time_phase_w == '0)
    else $error("sector 0 with nonzero time");

  // no compare time exceeds the period the word was started with
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> result.time_phase_u <= ts_out && result.time_phase_v <= ts_out &&
      result.time_phase_w <= ts_out)
    else $error("compare time above period");

  // a result always carries a valid sector code
  a_sector_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.sector != 3'd7)
    else $error("bad sector code");

endmodule
